// File: design/efws_pkg.sv
// Shared types and constants for the earliest-free-worker scheduler.
`default_nettype none
package efws_pkg;

    localparam int unsigned NUM_WORKERS_DEF = 16;
    localparam int unsigned TIME_BITS_DEF   = 48;
    localparam int unsigned DUR_W           = 32;
    localparam int unsigned WORKER_W        = 4;
    localparam int unsigned ACTIVE_W        = 5;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

    typedef struct packed {
        logic start;
        logic issue;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic last_read;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// File: design/efws_datapath.sv
// Datapath: worker count, free-time memory, scan comparator, adder and result register.
`default_nettype none
module efws_datapath #(
    parameter int unsigned NUM_WORKERS = efws_pkg::NUM_WORKERS_DEF,
    parameter int unsigned TIME_BITS   = efws_pkg::TIME_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire efws_pkg::t_dp_cmd                i_cmd,
    output efws_pkg::t_dp_sts                     o_sts,
    input  wire logic                             i_cfg_we,
    input  wire logic [efws_pkg::ACTIVE_W-1:0]    i_cfg_wdata,
    input  wire logic [efws_pkg::DUR_W-1:0]       i_dur,
    input  wire logic                             i_out_ready,
    output logic                                  o_out_valid,
    output logic [efws_pkg::WORKER_W-1:0]         o_worker,
    output logic [TIME_BITS-1:0]                  o_start,
    output logic                                  o_sat
);

    localparam int unsigned IDX_W = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
    localparam int unsigned CNT_W = $clog2(NUM_WORKERS + 1);
    localparam int unsigned CMP_W = (CNT_W > efws_pkg::ACTIVE_W) ? CNT_W : efws_pkg::ACTIVE_W;

    logic [efws_pkg::ACTIVE_W-1:0] r_active;
    logic [efws_pkg::DUR_W-1:0]    r_dur;
    logic [IDX_W-1:0]              r_addr;
    logic [TIME_BITS-1:0]          r_free_mem [NUM_WORKERS];
    logic [NUM_WORKERS-1:0]        r_valid;
    logic [TIME_BITS-1:0]          r_rd_q;
    logic                          r_rd_v;
    logic [IDX_W-1:0]              r_rd_idx;
    logic                          r_rd_live;
    logic [TIME_BITS-1:0]          r_best;
    logic [IDX_W-1:0]              r_best_idx;
    logic                          r_out_valid;
    logic [efws_pkg::WORKER_W-1:0] r_out_worker;
    logic [TIME_BITS-1:0]          r_out_start;
    logic                          r_out_sat;

    logic [CMP_W-1:0]     act_ext;
    logic [CMP_W-1:0]     n_eff;
    logic [TIME_BITS-1:0] rd_val;
    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] n_free;

    always_comb begin
        act_ext = CMP_W'(r_active);
        if (act_ext == '0) begin
            n_eff = CMP_W'(1);
        end else if (act_ext > CMP_W'(NUM_WORKERS)) begin
            n_eff = CMP_W'(NUM_WORKERS);
        end else begin
            n_eff = act_ext;
        end
    end

    assign o_sts.last_read = ((CMP_W'(r_addr) + CMP_W'(1)) == n_eff);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign rd_val = r_rd_v ? r_rd_q : '0;
    assign sum    = {1'b0, r_best} + (TIME_BITS + 1)'(r_dur);
    assign n_free = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= efws_pkg::ACTIVE_RESET;
            r_valid     <= '0;
            r_rd_live   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            if (i_cmd.commit) begin
                r_valid[r_best_idx] <= 1'b1;
            end
            r_rd_live <= i_cmd.issue;
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_q <= r_free_mem[r_addr];
        end
        if (i_cmd.commit) begin
            r_free_mem[r_best_idx] <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_dur  <= i_dur;
            r_addr <= '0;
        end else if (i_cmd.issue) begin
            r_addr <= r_addr + IDX_W'(1);
        end
        if (i_cmd.issue) begin
            r_rd_v   <= r_valid[r_addr];
            r_rd_idx <= r_addr;
        end
        if (r_rd_live && ((r_rd_idx == '0) || (rd_val < r_best))) begin
            r_best     <= rd_val;
            r_best_idx <= r_rd_idx;
        end
        if (i_cmd.commit) begin
            r_out_worker <= efws_pkg::WORKER_W'(r_best_idx);
            r_out_start  <= r_best;
            r_out_sat    <= sum[TIME_BITS];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_worker    = r_out_worker;
    assign o_start     = r_out_start;
    assign o_sat       = r_out_sat;

endmodule
`default_nettype wire

// File: design/efws_ctrl.sv
// Controller state machine that sequences the scan and the commit of each job.
`default_nettype none
module efws_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire efws_pkg::t_dp_sts i_sts,
    output efws_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_COMMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.start  = 1'b0;
        o_cmd.issue  = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_read) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                o_cmd.commit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// File: design/earliest_free_worker_scheduler_unit.sv
// Top level of the earliest-free-worker scheduler.
//
// Channel   Direction  Contents
// s_axis    in         duration of one job
// m_axis    out        assigned worker, its start time, saturation flag
// cfg       in         number of active workers
//
// A job reads the free-time memory once per active worker and compares the values
// through a single comparator.
// Reset clears the free times and sets the worker count to sixteen.
// A finished result waits in the output register; the next job is accepted and
// scanned meanwhile, and only its commit waits for that register to empty.
`default_nettype none
module earliest_free_worker_scheduler_unit #(
    parameter int unsigned NUM_WORKERS = efws_pkg::NUM_WORKERS_DEF,
    parameter int unsigned TIME_BITS   = efws_pkg::TIME_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // duration
    input  wire logic [efws_pkg::DUR_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // worker, start_time, saturated, zero padding
    output logic [((TIME_BITS + 12) / 8) * 8 - 1:0] m_axis_tdata,
    input  wire logic                          i_cfg_we,
    input  wire logic [efws_pkg::ACTIVE_W-1:0] i_cfg_wdata
);

    localparam int unsigned OUT_W = ((TIME_BITS + 12) / 8) * 8;

    efws_pkg::t_dp_cmd             cmd;
    efws_pkg::t_dp_sts             sts;
    logic [efws_pkg::WORKER_W-1:0] worker;
    logic [TIME_BITS-1:0]          start_time;
    logic                          saturated;

    efws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    efws_datapath #(
        .NUM_WORKERS (NUM_WORKERS),
        .TIME_BITS   (TIME_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_dur       (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_worker    (worker),
        .o_start     (start_time),
        .o_sat       (saturated)
    );

    assign m_axis_tdata = OUT_W'({saturated, start_time, worker});

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted again while a job was in progress");

    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result committed over a transaction still waiting");

    a_commit_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!s_axis_tready && !cmd.issue))
        else $error("commit issued outside the commit phase");

endmodule
`default_nettype wire

// File: test/efws_schedule_checker.sv
// Checker that predicts the worker assignment of every job and compares each result transaction.
module efws_schedule_checker #(
    parameter int unsigned NUM_WORKERS = efws_pkg::NUM_WORKERS_DEF,
    parameter int unsigned TIME_BITS   = efws_pkg::TIME_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    input  wire logic                                i_s_tready,
    // duration
    input  wire logic [efws_pkg::DUR_W-1:0]          i_s_tdata,
    input  wire logic                                i_m_tvalid,
    input  wire logic                                i_m_tready,
    // worker, start_time, saturated, zero padding
    input  wire logic [((TIME_BITS + 12) / 8) * 8 - 1:0] i_m_tdata,
    input  wire logic                                i_cfg_we,
    input  wire logic [efws_pkg::ACTIVE_W-1:0]       i_cfg_wdata,
    output int                                       o_errors,
    output int                                       o_outstanding
);

    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        logic [efws_pkg::WORKER_W-1:0] worker;
        t_time                         start_time;
        logic                          saturated;
    } t_assignment;

    localparam t_time TIME_LIMIT = '1;

    t_time                         free_at [NUM_WORKERS];
    logic [efws_pkg::ACTIVE_W-1:0] worker_limit;
    t_assignment                   assignments_due [$];

    initial begin
        o_errors      = 0;
        o_outstanding = 0;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch in %s: got %0h, expected %0h", what, got, want);
        o_errors++;
    endtask

    function automatic t_assignment assign_job(logic [efws_pkg::DUR_W-1:0] dur);
        int unsigned         n;
        int unsigned         best;
        logic [TIME_BITS:0]  total;
        t_assignment         a;
        if (worker_limit == 0) begin
            n = 1;
        end else if (worker_limit > NUM_WORKERS) begin
            n = NUM_WORKERS;
        end else begin
            n = worker_limit;
        end
        best = 0;
        for (int unsigned j = 1; j < n; j++) begin
            if (free_at[j] < free_at[best]) begin
                best = j;
            end
        end
        total        = {1'b0, free_at[best]}
                       + {{(TIME_BITS + 1 - efws_pkg::DUR_W){1'b0}}, dur};
        a.worker     = efws_pkg::WORKER_W'(best);
        a.start_time = free_at[best];
        a.saturated  = total > {1'b0, TIME_LIMIT};
        free_at[best] = a.saturated ? TIME_LIMIT : total[TIME_BITS-1:0];
        return a;
    endfunction

    always @(posedge i_clk) begin : track_jobs
        t_assignment want;
        t_assignment got;
        if (!i_rst_n) begin
            foreach (free_at[k]) begin
                free_at[k] = '0;
            end
            worker_limit = efws_pkg::ACTIVE_RESET;
            assignments_due.delete();
        end else begin
            if (i_cfg_we) begin
                worker_limit = i_cfg_wdata;
            end
            if (i_m_tvalid && i_m_tready) begin
                got.worker     = i_m_tdata[efws_pkg::WORKER_W-1:0];
                got.start_time = i_m_tdata[efws_pkg::WORKER_W +: TIME_BITS];
                got.saturated  = i_m_tdata[efws_pkg::WORKER_W + TIME_BITS];
                if (assignments_due.size() == 0) begin
                    report_mismatch("result with no job outstanding", 64'(got.start_time), '0);
                end else begin
                    want = assignments_due.pop_front();
                    if (got.worker != want.worker) begin
                        report_mismatch("worker", 64'(got.worker), 64'(want.worker));
                    end
                    if (got.start_time != want.start_time) begin
                        report_mismatch("start_time", 64'(got.start_time),
                                        64'(want.start_time));
                    end
                    if (got.saturated != want.saturated) begin
                        report_mismatch("saturated", 64'(got.saturated), 64'(want.saturated));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                assignments_due = {assignments_due, assign_job(i_s_tdata)};
            end
        end
        o_outstanding <= assignments_due.size();
    end

endmodule

// File: test/earliest_free_worker_scheduler_unit_tb.sv
// Testbench top that drives jobs and worker counts into the scheduler and gives the verdict.
module earliest_free_worker_scheduler_unit_tb;

    localparam int OUT_W = ((efws_pkg::TIME_BITS_DEF + 12) / 8) * 8;
    localparam logic [efws_pkg::DUR_W-1:0] DUR_MAX = '1;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic [efws_pkg::DUR_W-1:0]    s_axis_tdata  = '0;
    logic                          m_axis_tready = 1'b0;
    logic                          i_cfg_we      = 1'b0;
    logic [efws_pkg::ACTIVE_W-1:0] i_cfg_wdata   = '0;
    logic                          s_axis_tready;
    logic                          m_axis_tvalid;
    logic [OUT_W-1:0]              m_axis_tdata;
    int                            errors;
    int                            outstanding;
    int unsigned                   tx_idle_pct = 25;
    int unsigned                   rx_idle_pct = 62;

    earliest_free_worker_scheduler_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    efws_schedule_checker u_sched_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        #50000000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_job(logic [efws_pkg::DUR_W-1:0] dur);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= dur;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (25) @(posedge i_clk);
    endtask

    task automatic write_workers(logic [efws_pkg::ACTIVE_W-1:0] count);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [efws_pkg::DUR_W-1:0] random_duration();
        case ($urandom_range(9))
            0:       return '0;
            1:       return DUR_MAX;
            2, 3:    return $urandom_range(15);
            4, 5:    return $urandom_range(5000);
            6:       return $urandom | 32'hF000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [efws_pkg::DUR_W-1:0]    corner_durs [12] = '{
            32'h0, 32'h0, DUR_MAX, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h5555_5555, 32'hAAAA_AAAA, 32'h2, 32'h2, 32'h0, DUR_MAX
        };
        logic [efws_pkg::ACTIVE_W-1:0] seg_workers [6] = '{5'd16, 5'd3, 5'd31, 5'd9, 5'd0, 5'd1};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sixteen workers from reset, then a zero count and counts above the worker total.
        foreach (corner_durs[k]) begin
            send_job(corner_durs[k]);
        end
        wait_idle();
        write_workers(5'd0);
        send_job(32'h1);
        send_job(32'h0);
        send_job(32'h5);
        wait_idle();
        write_workers(5'd31);
        repeat (4) send_job($urandom_range(20));
        wait_idle();
        write_workers(5'd17);
        repeat (3) send_job($urandom_range(20));

        for (int seg = 0; seg < 6; seg++) begin
            wait_idle();
            tx_idle_pct = (seg < 2) ? 25 : (seg < 4) ? 62 : 0;
            rx_idle_pct = (seg < 2) ? 62 : (seg < 4) ? 25 : 0;
            write_workers((seg == 5) ? efws_pkg::ACTIVE_W'($urandom_range(31))
                                     : seg_workers[seg]);
            repeat (75) begin
                send_job(random_duration());
                if ($urandom_range(59) == 0) begin
                    wait_idle();
                end
            end
        end

        // One worker loaded with a run of the longest jobs.
        wait_idle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_workers(5'd1);
        repeat (8) send_job(DUR_MAX);
        send_job(32'h0);
        send_job(32'h1);
        send_job(32'h0);
        wait_idle();
        write_workers(5'd0);
        send_job(32'h0);
        send_job(DUR_MAX);
        wait_idle();
        write_workers(5'd2);
        repeat (4) send_job(random_duration());
        wait_idle();
        write_workers(5'd16);
        repeat (20) send_job(random_duration());
        wait_idle();

        if (errors == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/efws_pkg.sv
design/efws_datapath.sv
design/efws_ctrl.sv
design/earliest_free_worker_scheduler_unit.sv
test/efws_schedule_checker.sv
test/earliest_free_worker_scheduler_unit_tb.sv
